// File: hdl/aifs_pkg.sv
// aifs_pkg: shared widths, reset values, map coefficients and types for the
// affine IFS (fern) point generator. No dependencies.
`default_nettype none

package aifs_pkg;

	// geometry and fixed point format
	localparam int GRID_SIZE     = 4096;
	localparam int FRACTION_BITS = 18;
	localparam int POINT_W       = FRACTION_BITS + 6;
	localparam int COEF_W        = FRACTION_BITS + 2;
	localparam int PROD_W        = POINT_W + COEF_W;
	localparam int ACC_W         = PROD_W + 1;
	localparam int SH_W          = ACC_W - FRACTION_BITS;

	// field and register widths
	localparam int RAND_W     = 16;
	localparam int THR_W      = 16;
	localparam int SCALE_W    = 12;
	localparam int PIX_W      = 12;
	localparam int MAP_W      = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// pixel scaling widths
	localparam int SPROD_W  = POINT_W + SCALE_W + 1;
	localparam int PIXSUM_W = SPROD_W + 1;
	localparam int PIXT_W   = PIXSUM_W - FRACTION_BITS;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register reset values
	localparam logic [THR_W-1:0]   THR_FIRST_RST  = THR_W'(6554);
	localparam logic [THR_W-1:0]   THR_SECOND_RST = THR_W'(56361);
	localparam logic [THR_W-1:0]   THR_THIRD_RST  = THR_W'(60948);
	localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(290);
	localparam logic [SCALE_W-1:0] OFFSET_RST     = SCALE_W'(1500);

	typedef enum logic [MAP_W-1:0] {
		MAP_STEM  = 2'd0,
		MAP_MAIN  = 2'd1,
		MAP_LEFT  = 2'd2,
		MAP_RIGHT = 2'd3
	} map_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THR_FIRST  = 3'd0,
		REG_THR_SECOND = 3'd1,
		REG_THR_THIRD  = 3'd2,
		REG_PIX_SCALE  = 3'd3,
		REG_COL_OFFSET = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ACC,
		BK_PIX,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic [THR_W-1:0]   thr_first;
		logic [THR_W-1:0]   thr_second;
		logic [THR_W-1:0]   thr_third;
		logic [SCALE_W-1:0] pixel_scale;
		logic [SCALE_W-1:0] column_offset;
	} cfg_t;

	// one queue slot: the map picked for an item
	typedef struct packed {
		logic valid;
		map_t sel;
	} q_entry_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	// hundredths to fixed point, rounded to nearest, ties away from zero
	function automatic coef_t coef_fixed(input int h);
		longint m;
		longint q;
		m = (h < 0) ? -longint'(h) : longint'(h);
		q = (m * (longint'(1) << FRACTION_BITS) + 50) / 100;
		return (h < 0) ? coef_t'(-q) : coef_t'(q);
	endfunction

	// x' = a*x + b*y (no map has an x offset), y' = c*x + d*y + f
	localparam coef_t COEF_A [4] = '{coef_fixed(0), coef_fixed(85),
		coef_fixed(20), coef_fixed(-15)};
	localparam coef_t COEF_B [4] = '{coef_fixed(0), coef_fixed(4),
		coef_fixed(-26), coef_fixed(28)};
	localparam coef_t COEF_C [4] = '{coef_fixed(0), coef_fixed(-4),
		coef_fixed(23), coef_fixed(26)};
	localparam coef_t COEF_D [4] = '{coef_fixed(16), coef_fixed(85),
		coef_fixed(22), coef_fixed(24)};
	localparam coef_t COEF_F [4] = '{coef_fixed(0), coef_fixed(160),
		coef_fixed(160), coef_fixed(44)};

endpackage

`default_nettype wire

// File: hdl/aifs_sample_if.sv
// aifs_sample_if: valid/ready channel that carries one random fraction per item.
// Depends on aifs_pkg.
`default_nettype none

interface aifs_sample_if;
	logic                        valid;
	logic                        ready;
	logic [aifs_pkg::RAND_W-1:0] random_fraction;

	modport source (output valid, output random_fraction, input ready);
	modport sink (input valid, input random_fraction, output ready);
endinterface

`default_nettype wire

// File: hdl/aifs_pixel_if.sv
// aifs_pixel_if: valid/ready channel that carries one plotted pixel per item.
// Depends on aifs_pkg.
`default_nettype none

interface aifs_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [aifs_pkg::PIX_W-1:0] pixel_column;
	logic [aifs_pkg::PIX_W-1:0] pixel_row;
	logic                       in_range;
	logic [aifs_pkg::MAP_W-1:0] map_used;

	modport source (output valid, output pixel_column, output pixel_row,
		output in_range, output map_used, input ready);
	modport sink (input valid, input pixel_column, input pixel_row,
		input in_range, input map_used, output ready);
endinterface

`default_nettype wire

// File: hdl/aifs_queue.sv
// aifs_queue: short first-in first-out queue of map selections between the
// front and the back. Depends on aifs_pkg.
`default_nettype none

module aifs_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  aifs_pkg::q_entry_t wr,
	input  wire                rd_en,
	output aifs_pkg::q_entry_t rd,
	output logic               full
);

	aifs_pkg::map_t               slot_q [aifs_pkg::QUEUE_DEPTH];
	logic [aifs_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [aifs_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [aifs_pkg::QCNT_W-1:0]  count_q;
	logic                         do_wr;
	logic                         do_rd;

	assign full  = (count_q == aifs_pkg::QCNT_W'(aifs_pkg::QUEUE_DEPTH));
	assign do_wr = wr.valid && !full;
	assign do_rd = rd_en && (count_q != '0);

	// head of the queue
	assign rd.valid = (count_q != '0);
	assign rd.sel   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr.sel;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == aifs_pkg::QPTR_W'(aifs_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == aifs_pkg::QPTR_W'(aifs_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/aifs_front.sv
// aifs_front: accepts random fractions and picks the affine map for each item
// by threshold compare. Depends on aifs_pkg and aifs_sample_if.
`default_nettype none

module aifs_front (
	aifs_sample_if.sink        sample,
	input  aifs_pkg::cfg_t     cfg,
	input  wire                q_full,
	output aifs_pkg::q_entry_t push
);

	aifs_pkg::map_t sel;

	// ordered compares, first hit wins
	always_comb begin
		if (sample.random_fraction < cfg.thr_first) begin
			sel = aifs_pkg::MAP_STEM;
		end else if (sample.random_fraction < cfg.thr_second) begin
			sel = aifs_pkg::MAP_MAIN;
		end else if (sample.random_fraction < cfg.thr_third) begin
			sel = aifs_pkg::MAP_LEFT;
		end else begin
			sel = aifs_pkg::MAP_RIGHT;
		end
	end

	assign sample.ready = !q_full;
	assign push.valid   = sample.valid && !q_full;
	assign push.sel     = sel;

endmodule

`default_nettype wire

// File: hdl/aifs_back.sv
// aifs_back: sequencer that applies the chosen map to the stored point, scales
// the new point to a pixel and holds the result. Depends on aifs_pkg, aifs_pixel_if.
`default_nettype none

module aifs_back (
	input  wire                clk,
	input  wire                arst_n,
	input  aifs_pkg::cfg_t     cfg,
	input  aifs_pkg::q_entry_t head,
	output logic               pop,
	aifs_pixel_if.source       pixel
);

	localparam int FB = aifs_pkg::FRACTION_BITS;
	localparam logic signed [aifs_pkg::ACC_W-1:0] ROUND_HALF =
		aifs_pkg::ACC_W'(longint'(1) << (FB - 1));
	localparam logic signed [aifs_pkg::SH_W-1:0] SAT_HI =
		aifs_pkg::SH_W'((longint'(1) << (aifs_pkg::POINT_W - 1)) - 1);
	localparam logic signed [aifs_pkg::SH_W-1:0] SAT_LO =
		aifs_pkg::SH_W'(-(longint'(1) << (aifs_pkg::POINT_W - 1)));
	localparam logic signed [aifs_pkg::PIXSUM_W-1:0] TRUNC_BIAS =
		aifs_pkg::PIXSUM_W'((longint'(1) << FB) - 1);
	localparam logic signed [aifs_pkg::PIXT_W-1:0] GRID_LIM =
		aifs_pkg::PIXT_W'(aifs_pkg::GRID_SIZE);

	aifs_pkg::bk_state_t state_q;
	aifs_pkg::bk_state_t state_next;
	logic                load_out;

	aifs_pkg::map_t                         sel_q;
	logic signed [aifs_pkg::POINT_W-1:0]    px_q;
	logic signed [aifs_pkg::POINT_W-1:0]    py_q;
	logic signed [aifs_pkg::PROD_W-1:0]     ax_q;
	logic signed [aifs_pkg::PROD_W-1:0]     by_q;
	logic signed [aifs_pkg::PROD_W-1:0]     cx_q;
	logic signed [aifs_pkg::PROD_W-1:0]     dy_q;
	logic signed [aifs_pkg::SPROD_W-1:0]    col_prod_q;
	logic signed [aifs_pkg::SPROD_W-1:0]    row_prod_q;

	logic signed [aifs_pkg::PROD_W-1:0]     ax;
	logic signed [aifs_pkg::PROD_W-1:0]     by;
	logic signed [aifs_pkg::PROD_W-1:0]     cx;
	logic signed [aifs_pkg::PROD_W-1:0]     dy;
	logic signed [aifs_pkg::ACC_W-1:0]      acc_x;
	logic signed [aifs_pkg::ACC_W-1:0]      acc_y;
	logic signed [aifs_pkg::POINT_W-1:0]    nx;
	logic signed [aifs_pkg::POINT_W-1:0]    ny;
	logic signed [aifs_pkg::SCALE_W:0]      scale_s;
	logic signed [aifs_pkg::PIXSUM_W-1:0]   off_fix;
	logic signed [aifs_pkg::PIXSUM_W-1:0]   col_sum;
	logic signed [aifs_pkg::PIXSUM_W-1:0]   row_sum;
	logic [aifs_pkg::PIX_W:0]               col_pix;
	logic [aifs_pkg::PIX_W:0]               row_pix;

	logic [aifs_pkg::PIX_W-1:0] col_q;
	logic [aifs_pkg::PIX_W-1:0] row_q;
	logic                       ok_q;
	aifs_pkg::map_t             map_q;
	logic                       out_valid_q;

	// floor after rounding, then saturate to the point range
	function automatic logic signed [aifs_pkg::POINT_W-1:0] round_sat(
		input logic signed [aifs_pkg::ACC_W-1:0] acc);
		logic signed [aifs_pkg::SH_W-1:0] sh;
		sh = acc[aifs_pkg::ACC_W-1:FB];
		if (sh > SAT_HI) begin
			return aifs_pkg::POINT_W'(SAT_HI);
		end else if (sh < SAT_LO) begin
			return aifs_pkg::POINT_W'(SAT_LO);
		end
		return aifs_pkg::POINT_W'(sh);
	endfunction

	// truncate toward zero and clamp to the grid; top bit is the in-grid flag
	function automatic logic [aifs_pkg::PIX_W:0] pix_clamp(
		input logic signed [aifs_pkg::PIXSUM_W-1:0] v);
		logic signed [aifs_pkg::PIXSUM_W-1:0] b;
		logic signed [aifs_pkg::PIXT_W-1:0]   t;
		b = v + (v[aifs_pkg::PIXSUM_W-1] ? TRUNC_BIAS : '0);
		t = b[aifs_pkg::PIXSUM_W-1:FB];
		if (t < 0) begin
			return {1'b0, aifs_pkg::PIX_W'(0)};
		end else if (t >= GRID_LIM) begin
			return {1'b0, aifs_pkg::PIX_W'(aifs_pkg::GRID_SIZE - 1)};
		end
		return {1'b1, t[aifs_pkg::PIX_W-1:0]};
	endfunction

	// map products from the queue head and the stored point
	assign ax = px_q * aifs_pkg::COEF_A[head.sel];
	assign by = py_q * aifs_pkg::COEF_B[head.sel];
	assign cx = px_q * aifs_pkg::COEF_C[head.sel];
	assign dy = py_q * aifs_pkg::COEF_D[head.sel];

	// map sums with the constant term and rounding half
	assign acc_x = aifs_pkg::ACC_W'(ax_q) + aifs_pkg::ACC_W'(by_q) + ROUND_HALF;
	assign acc_y = aifs_pkg::ACC_W'(cx_q) + aifs_pkg::ACC_W'(dy_q)
		+ (aifs_pkg::ACC_W'(aifs_pkg::COEF_F[sel_q]) <<< FB) + ROUND_HALF;
	assign nx = round_sat(acc_x);
	assign ny = round_sat(acc_y);

	// pixel scaling sums
	assign scale_s = $signed({1'b0, cfg.pixel_scale});
	assign off_fix = $signed(aifs_pkg::PIXSUM_W'(cfg.column_offset) << FB);
	assign col_sum = aifs_pkg::PIXSUM_W'(col_prod_q) + off_fix;
	assign row_sum = aifs_pkg::PIXSUM_W'(row_prod_q);
	assign col_pix = pix_clamp(col_sum);
	assign row_pix = pix_clamp(row_sum);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aifs_pkg::BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state, queue pop and output load
	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			aifs_pkg::BK_IDLE: begin
				if (head.valid) begin
					pop        = 1'b1;
					state_next = aifs_pkg::BK_ACC;
				end
			end
			aifs_pkg::BK_ACC: begin
				state_next = aifs_pkg::BK_PIX;
			end
			aifs_pkg::BK_PIX: begin
				state_next = aifs_pkg::BK_FIN;
			end
			aifs_pkg::BK_FIN: begin
				if (!out_valid_q || pixel.ready) begin
					load_out   = 1'b1;
					state_next = aifs_pkg::BK_IDLE;
				end
			end
			default: begin
				state_next = aifs_pkg::BK_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			sel_q <= head.sel;
			ax_q  <= ax;
			by_q  <= by;
			cx_q  <= cx;
			dy_q  <= dy;
		end
		if (state_q == aifs_pkg::BK_PIX) begin
			col_prod_q <= px_q * scale_s;
			row_prod_q <= py_q * scale_s;
		end
		if (load_out) begin
			col_q <= col_pix[aifs_pkg::PIX_W-1:0];
			row_q <= row_pix[aifs_pkg::PIX_W-1:0];
			ok_q  <= col_pix[aifs_pkg::PIX_W] & row_pix[aifs_pkg::PIX_W];
			map_q <= sel_q;
		end
	end

	// current point, origin after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (state_q == aifs_pkg::BK_ACC) begin
			px_q <= nx;
			py_q <= ny;
		end
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_column = col_q;
	assign pixel.pixel_row    = row_q;
	assign pixel.in_range     = ok_q;
	assign pixel.map_used     = map_q;

endmodule

`default_nettype wire

// File: hdl/affine_ifs_point_generator.sv
// affine_ifs_point_generator: top level of the fern point generator with the
// configuration registers. Depends on aifs_pkg, the channel interfaces,
// aifs_front, aifs_queue and aifs_back.
`default_nettype none

// Chaos-game point generator for the Barnsley fern. Each item on the sample
// channel carries a 16-bit random fraction; the front compares it with three
// thresholds and queues the chosen map in a two-entry queue, so it keeps taking
// items while the back is busy, until the queue fills. The back runs a four-step
// sequencer per item (map products, round and saturate into the stored point,
// pixel scaling multiply, truncate and clamp into the output register) and
// takes the next item only after the last is loaded into the output register.
// The point starts at the origin after reset. Registers are written through
// cfg_wen, cfg_index and cfg_wdata; the user must write them only while the
// block is idle, which it does not enforce; unknown indexes are ignored.
module affine_ifs_point_generator (
	input  wire                               clk,
	input  wire                               arst_n,
	aifs_sample_if.sink                       sample,
	aifs_pixel_if.source                      pixel,
	input  wire                               cfg_wen,
	input  wire [aifs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [aifs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	aifs_pkg::cfg_t     cfg_q;
	aifs_pkg::q_entry_t q_wr;
	aifs_pkg::q_entry_t q_rd;
	logic               q_full;
	logic               q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_first     <= aifs_pkg::THR_FIRST_RST;
			cfg_q.thr_second    <= aifs_pkg::THR_SECOND_RST;
			cfg_q.thr_third     <= aifs_pkg::THR_THIRD_RST;
			cfg_q.pixel_scale   <= aifs_pkg::SCALE_RST;
			cfg_q.column_offset <= aifs_pkg::OFFSET_RST;
		end else if (cfg_wen) begin
			case (aifs_pkg::reg_idx_t'(cfg_index))
				aifs_pkg::REG_THR_FIRST: begin
					cfg_q.thr_first <= cfg_wdata[aifs_pkg::THR_W-1:0];
				end
				aifs_pkg::REG_THR_SECOND: begin
					cfg_q.thr_second <= cfg_wdata[aifs_pkg::THR_W-1:0];
				end
				aifs_pkg::REG_THR_THIRD: begin
					cfg_q.thr_third <= cfg_wdata[aifs_pkg::THR_W-1:0];
				end
				aifs_pkg::REG_PIX_SCALE: begin
					cfg_q.pixel_scale <= cfg_wdata[aifs_pkg::SCALE_W-1:0];
				end
				aifs_pkg::REG_COL_OFFSET: begin
					cfg_q.column_offset <= cfg_wdata[aifs_pkg::SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	aifs_front u_front (
		.sample (sample),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (q_wr)
	);

	// queue of map selections
	aifs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.rd_en  (q_pop),
		.rd     (q_rd),
		.full   (q_full)
	);

	// back: map, scale, output register
	aifs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (q_rd),
		.pop    (q_pop),
		.pixel  (pixel)
	);

	// an item pushed into an empty queue shows at the head next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid && !q_rd.valid |=> q_rd.valid && (q_rd.sel == $past(q_wr.sel)))
		else $error("queue head does not match item pushed into empty queue");

	// a fraction under the first threshold always picks the stem map
	assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid && (sample.random_fraction < cfg_q.thr_first)
		|-> q_wr.sel == aifs_pkg::MAP_STEM)
		else $error("stem map not chosen below first threshold");

	// an off-grid result has a coordinate clamped to an edge of the grid
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && !pixel.in_range |->
		(pixel.pixel_column == '0) || (pixel.pixel_row == '0) ||
		(pixel.pixel_column == aifs_pkg::PIX_W'(aifs_pkg::GRID_SIZE - 1)) ||
		(pixel.pixel_row == aifs_pkg::PIX_W'(aifs_pkg::GRID_SIZE - 1)))
		else $error("off-grid pixel not clamped to the grid edge");

endmodule

`default_nettype wire

// File: tb/affine_ifs_point_generator_tb.sv
// affine_ifs_point_generator_tb: drives random fractions into the fern point
// generator and checks every plotted pixel against a cycle-free fern model.
// Depends on aifs_pkg, aifs_sample_if, aifs_pixel_if and affine_ifs_point_generator.
`default_nettype none

module affine_ifs_point_generator_tb;
	import aifs_pkg::*;

	localparam longint FIX_ONE  = longint'(1) <<< FRACTION_BITS;
	localparam longint FIX_HALF = FIX_ONE / 2;
	localparam longint POINT_HI = (longint'(1) <<< (POINT_W - 1)) - 1;
	localparam longint POINT_LO = -(longint'(1) <<< (POINT_W - 1));
	localparam int     HOLD_OFF_CYCLES = 300;
	localparam int     LATENCY_PAD = 8;

	// terms of one affine map; the x offset is zero for every map
	typedef enum int {
		TERM_A,
		TERM_B,
		TERM_C,
		TERM_D,
		TERM_F
	} term_t;

	typedef struct {
		logic [PIX_W-1:0] column;
		logic [PIX_W-1:0] row;
		logic             in_range;
		map_t             map_sel;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	aifs_sample_if sample_ch ();
	aifs_pixel_if  pixel_ch ();

	affine_ifs_point_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.pixel     (pixel_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// register copies and the fern point as the block should hold them
	logic [THR_W-1:0]        thr_first;
	logic [THR_W-1:0]        thr_second;
	logic [THR_W-1:0]        thr_third;
	logic [SCALE_W-1:0]      scale;
	logic [SCALE_W-1:0]      offset;
	logic signed [POINT_W-1:0] fern_x;
	logic signed [POINT_W-1:0] fern_y;

	pixel_t expected_pixels [$];
	int     mismatch_count = 0;

	// sender and receiver pacing
	bit sender_bursty;
	bit receiver_stalls;
	int burst_left;
	int hold_requests = 0;

	// coefficient in fixed point, rounded to nearest with ties away from zero
	function automatic longint fern_coef(input map_t m, input term_t t);
		int     h;
		longint mag;
		longint q;
		case (m)
			MAP_STEM: begin
				h = (t == TERM_D) ? 16 : 0;
			end
			MAP_MAIN: begin
				case (t)
					TERM_A: h = 85;
					TERM_B: h = 4;
					TERM_C: h = -4;
					TERM_D: h = 85;
					default: h = 160;
				endcase
			end
			MAP_LEFT: begin
				case (t)
					TERM_A: h = 20;
					TERM_B: h = -26;
					TERM_C: h = 23;
					TERM_D: h = 22;
					default: h = 160;
				endcase
			end
			default: begin
				case (t)
					TERM_A: h = -15;
					TERM_B: h = 28;
					TERM_C: h = 26;
					TERM_D: h = 24;
					default: h = 44;
				endcase
			end
		endcase
		mag = (h < 0) ? -longint'(h) : longint'(h);
		q = (mag * FIX_ONE + 50) / 100;
		return (h < 0) ? -q : q;
	endfunction

	// exact sum, round half up to the point grid, then saturate
	function automatic longint affine_coord(input longint ca, input longint cb,
		input longint ck, input longint x, input longint y);
		longint acc;
		longint r;
		acc = ca * x + cb * y + ck * FIX_ONE;
		r = (acc + FIX_HALF) >>> FRACTION_BITS;
		if (r > POINT_HI) r = POINT_HI;
		if (r < POINT_LO) r = POINT_LO;
		return r;
	endfunction

	function automatic longint trunc_fraction(input longint v);
		if (v >= 0)
			return v >>> FRACTION_BITS;
		return -((-v) >>> FRACTION_BITS);
	endfunction

	function automatic logic [PIX_W-1:0] clamp_to_grid(input longint p);
		if (p < 0)
			return '0;
		if (p >= GRID_SIZE)
			return PIX_W'(GRID_SIZE - 1);
		return PIX_W'(p);
	endfunction

	// next fern point for one fraction and the pixel it lands on
	task automatic predict_pixel(input logic [RAND_W-1:0] frac, output pixel_t p);
		map_t   sel;
		longint x;
		longint y;
		longint nx;
		longint ny;
		longint col;
		longint row;
		if (frac < thr_first)
			sel = MAP_STEM;
		else if (frac < thr_second)
			sel = MAP_MAIN;
		else if (frac < thr_third)
			sel = MAP_LEFT;
		else
			sel = MAP_RIGHT;
		x = longint'(fern_x);
		y = longint'(fern_y);
		nx = affine_coord(fern_coef(sel, TERM_A), fern_coef(sel, TERM_B), 0, x, y);
		ny = affine_coord(fern_coef(sel, TERM_C), fern_coef(sel, TERM_D),
			fern_coef(sel, TERM_F), x, y);
		fern_x = POINT_W'(nx);
		fern_y = POINT_W'(ny);
		col = trunc_fraction(nx * longint'(scale) + longint'(offset) * FIX_ONE);
		row = trunc_fraction(ny * longint'(scale));
		p.column   = clamp_to_grid(col);
		p.row      = clamp_to_grid(row);
		p.in_range = (col >= 0 && col < GRID_SIZE && row >= 0 && row < GRID_SIZE);
		p.map_sel  = sel;
	endtask

	// register write; bits above the register width are dropped
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_THR_FIRST:  thr_first  = data[THR_W-1:0];
			REG_THR_SECOND: thr_second = data[THR_W-1:0];
			REG_THR_THIRD:  thr_third  = data[THR_W-1:0];
			REG_PIX_SCALE:  scale      = data[SCALE_W-1:0];
			REG_COL_OFFSET: offset     = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [THR_W-1:0] t1, input logic [THR_W-1:0] t2,
		input logic [THR_W-1:0] t3, input logic [SCALE_W-1:0] sc, input logic [SCALE_W-1:0] off);
		write_reg(REG_THR_FIRST, CFG_DATA_W'(t1));
		write_reg(REG_THR_SECOND, CFG_DATA_W'(t2));
		write_reg(REG_THR_THIRD, CFG_DATA_W'(t3));
		write_reg(REG_PIX_SCALE, CFG_DATA_W'(sc));
		write_reg(REG_COL_OFFSET, CFG_DATA_W'(off));
	endtask

	// offer one item, with random gaps between bursts
	task automatic send_fraction(input logic [RAND_W-1:0] frac);
		int     gap;
		pixel_t p;
		if (burst_left == 0) begin
			gap = sender_bursty ? $urandom_range(0, 8) : 0;
			repeat (gap) begin
				@(negedge clk);
				sample_ch.valid           <= 1'b0;
				sample_ch.random_fraction <= RAND_W'($urandom);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		sample_ch.valid           <= 1'b1;
		sample_ch.random_fraction <= frac;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		predict_pixel(frac, p);
		expected_pixels.push_back(p);
		burst_left--;
	endtask

	// stop offering and let every outstanding pixel come out
	task automatic wait_for_results();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_fraction(RAND_W'($urandom_range(0, 65535)));
	endtask

	// reset values: map boundaries on both sides of each threshold
	task automatic test_reset_values();
		sender_bursty   = 1'b1;
		receiver_stalls = 1'b1;
		send_fraction(16'd0);
		send_fraction(THR_FIRST_RST - 1'b1);
		send_fraction(THR_FIRST_RST);
		send_fraction(THR_SECOND_RST - 1'b1);
		send_fraction(THR_SECOND_RST);
		send_fraction(THR_THIRD_RST - 1'b1);
		send_fraction(THR_THIRD_RST);
		send_fraction(16'hffff);
		wait_for_results();
	endtask

	// thresholds at both ends and out of order
	task automatic test_threshold_extremes();
		write_all(16'd0, 16'd0, 16'd0, SCALE_RST, OFFSET_RST);
		send_fraction(16'd0);
		send_fraction(16'hffff);
		wait_for_results();
		write_all(16'hffff, 16'hffff, 16'hffff, SCALE_RST, OFFSET_RST);
		send_fraction(16'hffff);
		send_fraction(16'hfffe);
		wait_for_results();
		// unordered: the main map can never win
		write_all(16'd1000, 16'd500, 16'd40000, SCALE_RST, OFFSET_RST);
		send_fraction(16'd600);
		send_fraction(16'd1200);
		send_fraction(16'd50000);
		wait_for_results();
	endtask

	// pixels that fall off the grid on each side
	task automatic test_off_grid();
		write_all(THR_FIRST_RST, THR_SECOND_RST, THR_THIRD_RST, 12'd4095, 12'd0);
		send_fraction(16'd30000);
		send_fraction(16'd30000);
		send_fraction(16'd30000);
		send_fraction(16'd58000);
		send_fraction(16'd58000);
		wait_for_results();
		write_reg(REG_COL_OFFSET, 16'd4095);
		send_fraction(16'hffff);
		send_fraction(16'hffff);
		wait_for_results();
	endtask

	// unknown indexes are ignored, wide data is cut to register width
	task automatic test_register_decode();
		int idx;
		for (idx = int'(REG_COL_OFFSET) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), 16'hffff);
		write_reg(REG_PIX_SCALE, 16'hf123);
		write_reg(REG_COL_OFFSET, 16'hffff);
		send_fraction(16'd20000);
		send_fraction(16'd62000);
		wait_for_results();
	endtask

	// long run of the stock fern
	task automatic test_random_fern();
		write_all(THR_FIRST_RST, THR_SECOND_RST, THR_THIRD_RST, SCALE_RST, OFFSET_RST);
		send_random(400);
		wait_for_results();
	endtask

	// several random settings, scale and offset extremes among them
	task automatic test_random_settings();
		int          phase;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [11:0] sc;
		logic [11:0] off;
		for (phase = 0; phase < 6; phase++) begin
			if (phase == 4) begin
				t1 = 16'($urandom_range(0, 65535));
				t2 = 16'($urandom_range(0, 65535));
				t3 = 16'($urandom_range(0, 65535));
			end else begin
				t1 = 16'($urandom_range(0, 20000));
				t2 = 16'($urandom_range(t1, 65535));
				t3 = 16'($urandom_range(t2, 65535));
			end
			case (phase)
				0: begin
					sc  = 12'd0;
					off = 12'd4095;
				end
				1: begin
					sc  = 12'd4095;
					off = 12'd2048;
				end
				default: begin
					sc  = 12'($urandom_range(0, 4095));
					off = 12'($urandom_range(0, 4095));
				end
			endcase
			write_all(t1, t2, t3, sc, off);
			send_random(80);
			wait_for_results();
		end
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_receiver_hold();
		write_all(THR_FIRST_RST, THR_SECOND_RST, THR_THIRD_RST, SCALE_RST, OFFSET_RST);
		sender_bursty = 1'b0;
		hold_requests++;
		send_random(40);
		wait_for_results();
		sender_bursty   = 1'b1;
		receiver_stalls = 1'b0;
		send_random(100);
		receiver_stalls = 1'b1;
		hold_requests++;
		send_random(80);
		wait_for_results();
	endtask

	// receiver: own stall pattern, plus long hold-offs on request
	initial begin : receiver
		int          holds_served;
		int          hold_left;
		int          pattern_pos;
		logic [15:0] stall_pattern;
		holds_served  = 0;
		hold_left     = 0;
		pattern_pos   = 0;
		stall_pattern = '1;
		pixel_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pixel_ch.ready <= 1'b0;
			end else if (!receiver_stalls) begin
				pixel_ch.ready <= 1'b1;
			end else begin
				if (pattern_pos == 0)
					stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'd1);
				pixel_ch.ready <= stall_pattern[pattern_pos];
				pattern_pos = (pattern_pos + 1) % 16;
			end
		end
	end

	// compare each accepted pixel with the oldest prediction
	always @(posedge clk) begin
		pixel_t exp_p;
		if (arst_n === 1'b1 && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel item with no prediction pending");
				mismatch_count++;
			end else begin
				exp_p = expected_pixels.pop_front();
				if (pixel_ch.pixel_column !== exp_p.column) begin
					$error("pixel_column: expected %0d, got %0d", exp_p.column,
						pixel_ch.pixel_column);
					mismatch_count++;
				end
				if (pixel_ch.pixel_row !== exp_p.row) begin
					$error("pixel_row: expected %0d, got %0d", exp_p.row, pixel_ch.pixel_row);
					mismatch_count++;
				end
				if (pixel_ch.in_range !== exp_p.in_range) begin
					$error("in_range: expected %0d, got %0d", exp_p.in_range, pixel_ch.in_range);
					mismatch_count++;
				end
				if (pixel_ch.map_used !== exp_p.map_sel) begin
					$error("map_used: expected %0d, got %0d", exp_p.map_sel, pixel_ch.map_used);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		sample_ch.valid           = 1'b0;
		sample_ch.random_fraction = '0;
		cfg_wen    = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		arst_n     = 1'b0;
		thr_first  = THR_FIRST_RST;
		thr_second = THR_SECOND_RST;
		thr_third  = THR_THIRD_RST;
		scale      = SCALE_RST;
		offset     = OFFSET_RST;
		fern_x     = '0;
		fern_y     = '0;
		burst_left = 0;
		sender_bursty   = 1'b1;
		receiver_stalls = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_threshold_extremes();
		test_off_grid();
		test_register_decode();
		test_random_fern();
		test_random_settings();
		test_receiver_hold();
		wait_for_results();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
